@@ hdl/lpp_pkg.sv @@
// Shared types, constants and elaboration-time table builders for the linear
// pitch to phase increment converter. No dependencies.

package lpp_pkg;

   localparam int FINE_STEPS   = 256;
   localparam int TAYLOR_TERMS = 12;
   localparam int PITCH_W      = 32;
   localparam int FRAC_W       = 16;
   localparam int OCT_W        = 16;
   localparam int INC_W        = 32;
   localparam int BASE_W       = 32;
   localparam int ENTRY_W      = 33;
   localparam int SUM_W        = 33;
   localparam int SHIFT_W      = 5;
   localparam int SLOPE_ROUND  = 128;
   localparam int SLOPE_SHIFT  = 8;

   localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AC;
   localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

   localparam logic signed [OCT_W-1:0] OCT_MAX = 16'sd7;
   localparam logic signed [OCT_W-1:0] OCT_MIN = -16'sd24;

   typedef logic [ENTRY_W-1:0] fine_table_type [FINE_STEPS+1];

   typedef struct packed {
      logic                    valid;
      logic signed [OCT_W-1:0] octave;
   } oct_stage_type;

   // Rounded product of two Q62 values, built from 32-bit partial products.
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] al, ah, bl, bh;
      logic [63:0] ll, lh, hl, hh;
      logic [63:0] mid, lo, hi, lo2;
      al  = {32'd0, a[31:0]};
      ah  = {32'd0, a[63:32]};
      bl  = {32'd0, b[31:0]};
      bh  = {32'd0, b[63:32]};
      ll  = al * bl;
      lh  = al * bh;
      hl  = ah * bl;
      hh  = ah * bh;
      mid = {32'd0, ll[63:32]} + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
      lo  = {mid[31:0], ll[31:0]};
      hi  = hh + {32'd0, lh[63:32]} + {32'd0, hl[63:32]} + {32'd0, mid[63:32]};
      lo2 = lo + (64'd1 << 61);
      if (lo2 < lo) begin
         hi = hi + 64'd1;
      end
      return {hi[61:0], lo2[63:62]};
   endfunction

   // Powers 2^(k/256) scaled by 2^31, rounded, with the last entry at 2^32.
   function automatic fine_table_type build_fine();
      fine_table_type fine;
      logic [63:0]    x, term, root, p, rnd;
      x    = (LN2_Q64 + 64'd512) >> 10;
      term = Q62_ONE;
      root = Q62_ONE;
      p    = Q62_ONE;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         term = mul_q62(term, x) / 64'(n);
         root = root + term;
      end
      for (int k = 0; k <= FINE_STEPS; k++) begin
         rnd     = p + (64'd1 << 30);
         fine[k] = rnd[31+ENTRY_W-1:31];
         p       = mul_q62(p, root);
      end
      fine[FINE_STEPS] = ENTRY_W'(64'd1 << 32);
      return fine;
   endfunction

endpackage

@@ hdl/linear_pitch_to_phase_increment_top.sv @@
// Top level of the linear pitch to phase increment converter.
// Depends on lpp_pkg, lpp_interp and lpp_scale.

// The block accepts one request in every clock cycle while busy is low. Each
// result passes the input register and both stage registers and is marked by
// rsp_strobe for one cycle. The path is an input register, a stage holding the
// segment lookup and one slope multiply, and a stage holding the add and the
// octave shift. Busy is high during reset and in the first cycle after it, and
// low from then on. The receiver cannot stall, so nothing holds a result back.

module linear_pitch_to_phase_increment_top #(
   parameter int SEGMENT_BITS = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [lpp_pkg::PITCH_W-1:0] req_pitch,
   output logic                               rsp_strobe,
   output logic [lpp_pkg::INC_W-1:0]          rsp_increment,
   output logic                               rsp_saturated
);

   localparam int PROD_W = 40 - 2 * SEGMENT_BITS;

   logic                              busy_ff;
   logic                              busy_in;
   logic                              valid_ff;
   logic                              valid_in;
   logic [lpp_pkg::PITCH_W-1:0]       pitch_ff;

   lpp_pkg::oct_stage_type            stage_a;
   lpp_pkg::oct_stage_type            stage_b;
   logic [lpp_pkg::BASE_W-1:0]        base_b;
   logic [PROD_W-1:0]                 product_b;

   assign busy_in  = 1'b0;
   assign valid_in = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pitch_ff <= req_pitch;
   end

   assign busy = busy_ff;

   assign stage_a.valid  = valid_ff;
   assign stage_a.octave = $signed(pitch_ff[lpp_pkg::PITCH_W-1:lpp_pkg::FRAC_W]);

   lpp_interp #(
      .SEGMENT_BITS (SEGMENT_BITS)
   ) u_interp (
      .clock       (clock),
      .reset       (reset),
      .stage_in    (stage_a),
      .frac        (pitch_ff[lpp_pkg::FRAC_W-1:0]),
      .stage_out   (stage_b),
      .base_out    (base_b),
      .product_out (product_b)
   );

   lpp_scale #(
      .SEGMENT_BITS (SEGMENT_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .stage_in  (stage_b),
      .base      (base_b),
      .product   (product_b),
      .strobe    (rsp_strobe),
      .increment (rsp_increment),
      .saturated (rsp_saturated)
   );

endmodule

@@ hdl/lpp_seg_rom.sv @@
// Constant segment table holding the base and slope of each interpolation segment.
// Depends on lpp_pkg for the fine power-of-two table builder.

module lpp_seg_rom #(
   parameter int  SEGMENT_BITS = 6,
   localparam int SLOPE_W      = 24 - SEGMENT_BITS
) (
   input  logic [SEGMENT_BITS-1:0]   seg,
   output logic [lpp_pkg::BASE_W-1:0] base,
   output logic [SLOPE_W-1:0]        slope
);

   localparam int SEG_COUNT = 1 << SEGMENT_BITS;
   localparam int STRIDE    = lpp_pkg::FINE_STEPS >> SEGMENT_BITS;

   typedef logic [lpp_pkg::BASE_W-1:0] base_rom_type [SEG_COUNT];
   typedef logic [SLOPE_W-1:0]         slope_rom_type [SEG_COUNT];

   localparam lpp_pkg::fine_table_type FINE = lpp_pkg::build_fine();

   function automatic base_rom_type build_base();
      base_rom_type t;
      for (int i = 0; i < SEG_COUNT; i++) begin
         t[i] = FINE[i*STRIDE][lpp_pkg::BASE_W-1:0];
      end
      return t;
   endfunction

   function automatic slope_rom_type build_slope();
      slope_rom_type                t;
      logic [lpp_pkg::ENTRY_W-1:0] d;
      for (int i = 0; i < SEG_COUNT; i++) begin
         d    = FINE[(i+1)*STRIDE] - FINE[i*STRIDE]
                + lpp_pkg::ENTRY_W'(lpp_pkg::SLOPE_ROUND);
         t[i] = SLOPE_W'(d >> lpp_pkg::SLOPE_SHIFT);
      end
      return t;
   endfunction

   localparam base_rom_type  BASE  = build_base();
   localparam slope_rom_type SLOPE = build_slope();

   assign base  = BASE[seg];
   assign slope = SLOPE[seg];

endmodule

@@ hdl/lpp_interp.sv @@
// First work stage: segment lookup and slope multiplication, registered.
// Depends on lpp_pkg and lpp_seg_rom.

module lpp_interp #(
   parameter int  SEGMENT_BITS = 6,
   localparam int SLOPE_W      = 24 - SEGMENT_BITS,
   localparam int LOW_W        = lpp_pkg::FRAC_W - SEGMENT_BITS,
   localparam int PROD_W       = SLOPE_W + LOW_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lpp_pkg::oct_stage_type        stage_in,
   input  logic [lpp_pkg::FRAC_W-1:0]    frac,
   output lpp_pkg::oct_stage_type        stage_out,
   output logic [lpp_pkg::BASE_W-1:0]    base_out,
   output logic [PROD_W-1:0]             product_out
);

   logic [SEGMENT_BITS-1:0]        seg;
   logic [LOW_W-1:0]               low;
   logic [lpp_pkg::BASE_W-1:0]     base_in;
   logic [SLOPE_W-1:0]             slope;
   logic [PROD_W-1:0]              product_in;

   logic                           valid_ff;
   logic signed [lpp_pkg::OCT_W-1:0] octave_ff;
   logic [lpp_pkg::BASE_W-1:0]     base_ff;
   logic [PROD_W-1:0]              product_ff;

   assign seg = frac[lpp_pkg::FRAC_W-1 -: SEGMENT_BITS];
   assign low = frac[LOW_W-1:0];

   lpp_seg_rom #(
      .SEGMENT_BITS (SEGMENT_BITS)
   ) u_seg_rom (
      .seg   (seg),
      .base  (base_in),
      .slope (slope)
   );

   assign product_in = {{LOW_W{1'b0}}, slope} * {{SLOPE_W{1'b0}}, low};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      octave_ff  <= stage_in.octave;
      base_ff    <= base_in;
      product_ff <= product_in;
   end

   assign stage_out.valid  = valid_ff;
   assign stage_out.octave = octave_ff;
   assign base_out         = base_ff;
   assign product_out      = product_ff;

endmodule

@@ hdl/lpp_scale.sv @@
// Second work stage: adds the interpolation term to the base and shifts by octave,
// with clamping for high octaves and a zero result below OCT_MIN. Depends on lpp_pkg.

module lpp_scale #(
   parameter int  SEGMENT_BITS = 6,
   localparam int PROD_W       = 40 - 2 * SEGMENT_BITS,
   localparam int INTERP_SHIFT = 8 - SEGMENT_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lpp_pkg::oct_stage_type      stage_in,
   input  logic [lpp_pkg::BASE_W-1:0]  base,
   input  logic [PROD_W-1:0]           product,
   output logic                        strobe,
   output logic [lpp_pkg::INC_W-1:0]   increment,
   output logic                        saturated
);

   logic [lpp_pkg::SUM_W-1:0]          sum;
   logic signed [lpp_pkg::OCT_W-1:0]   shift_full;
   logic [lpp_pkg::SHIFT_W-1:0]        shift_amt;
   logic [lpp_pkg::INC_W-1:0]          increment_in;
   logic                               saturated_in;

   logic                               strobe_ff;
   logic [lpp_pkg::INC_W-1:0]          increment_ff;
   logic                               saturated_ff;

   assign sum        = {1'b0, base} + lpp_pkg::SUM_W'(product >> INTERP_SHIFT);
   assign shift_full = lpp_pkg::OCT_MAX - stage_in.octave;
   assign shift_amt  = shift_full[lpp_pkg::SHIFT_W-1:0];

   always_comb begin
      increment_in = '0;
      saturated_in = 1'b0;
      if (stage_in.octave > lpp_pkg::OCT_MAX) begin
         increment_in = '1;
         saturated_in = 1'b1;
      end else if (stage_in.octave >= lpp_pkg::OCT_MIN) begin
         increment_in = lpp_pkg::INC_W'(sum >> shift_amt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      increment_ff <= increment_in;
      saturated_ff <= saturated_in;
   end

   assign strobe    = strobe_ff;
   assign increment = increment_ff;
   assign saturated = saturated_ff;

endmodule

@@ hdl/lpp_checker.sv @@
// Port-level assertions for the linear pitch to phase increment converter,
// bound to the top level. Depends on linear_pitch_to_phase_increment_top.

module lpp_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [31:0] req_pitch,
   input logic        rsp_strobe,
   input logic [31:0] rsp_increment,
   input logic        rsp_saturated
);

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("A taken request produced no result three cycles later.");

   a_no_extra : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 3))
      else $error("A result appeared without a matching request.");

   a_sat_value : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturated) |-> (rsp_increment == 32'hFFFF_FFFF))
      else $error("A saturated result is not all ones.");

   a_sat_sign : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturated) |-> !$past(req_pitch[31], 3))
      else $error("A negative octave was reported as saturated.");

endmodule

bind linear_pitch_to_phase_increment_top lpp_checker u_lpp_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_pitch     (req_pitch),
   .rsp_strobe    (rsp_strobe),
   .rsp_increment (rsp_increment),
   .rsp_saturated (rsp_saturated)
);
